// ----- src/mi3_pkg.sv -----
`timescale 1ns / 1ps
package mi3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // exact widths of the intermediates
    localparam int CW    = 2 * DATA_WIDTH + 1;      // cofactor
    localparam int PW    = 2 * DATA_WIDTH + 1;      // partial product of the determinant
    localparam int DETW  = 3 * DATA_WIDTH + 3;      // determinant
    localparam int SHIFT = 2 * FRAC_BITS + 1;
    localparam int NUMA  = 2 * DATA_WIDTH + 2 * FRAC_BITS + 2;
    localparam int NUMW  = (NUMA > DETW) ? NUMA : DETW;
    localparam int CMPW  = NUMW + DATA_WIDTH + 1;

    localparam int LANES = 9;
    // cofactor stages 2, determinant 2, divider prep 1, quotient bits, output 1
    localparam int LAT   = DATA_WIDTH + 6;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [CW-1:0]         t_cof;
    typedef logic signed [DETW-1:0]       t_det;

    typedef struct packed {
        t_data res;
        logic  sat;
        logic  zero;
    } t_lane_res;

    localparam t_data DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // cofactor k = a[P]*a[Q] - a[R]*a[S], elements indexed 3*row+col
    localparam int COF_P [LANES] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
    localparam int COF_Q [LANES] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
    localparam int COF_R [LANES] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
    localparam int COF_S [LANES] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

endpackage

// ----- src/mi3_if.sv -----
`timescale 1ns / 1ps
interface mi3_mat_if import mi3_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface mi3_inv_if import mi3_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic  singular;
    logic  overflow;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, overflow, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, overflow, output ready);
endinterface

// ----- src/mi3_cof.sv -----
`timescale 1ns / 1ps
module mi3_cof import mi3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_data i_p,
    input  t_data i_q,
    input  t_data i_r,
    input  t_data i_s,
    output t_cof  o_cof
);
    logic signed [2*DATA_WIDTH-1:0] r_pq, r_rs;
    t_cof r_cof;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pq  <= i_p * i_q;
            r_rs  <= i_r * i_s;
            r_cof <= t_cof'(r_pq) - t_cof'(r_rs);
        end
    end

    assign o_cof = r_cof;
endmodule

// ----- src/mi3_det.sv -----
`timescale 1ns / 1ps
module mi3_det import mi3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_data i_a [3],
    input  t_cof  i_c [3],
    output t_det  o_det
);
    logic signed [PW-1:0] r_lo [3];
    logic signed [PW-1:0] r_hi [3];
    t_det r_det, n_det;

    // split each cofactor into a low unsigned word and a high signed word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= i_a[j] * $signed({1'b0, i_c[j][DATA_WIDTH-1:0]});
                r_hi[j] <= i_a[j] * $signed(i_c[j][CW-1:DATA_WIDTH]);
            end
            r_det <= n_det;
        end
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (t_det'(r_hi[j]) <<< DATA_WIDTH) + t_det'(r_lo[j]);
        end
    end

    assign o_det = r_det;
endmodule

// ----- src/mi3_div.sv -----
`timescale 1ns / 1ps
module mi3_div import mi3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_cof      i_cof,
    input  t_det      i_det,
    output t_lane_res o_res
);
    logic [NUMW-1:0]       r_r    [DATA_WIDTH+1];
    logic [NUMW-1:0]       r_d    [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_q    [DATA_WIDTH+1];
    logic                  r_neg  [DATA_WIDTH+1];
    logic                  r_zero [DATA_WIDTH+1];
    logic                  r_big  [DATA_WIDTH+1];
    t_lane_res             r_res, n_res;

    t_cof              n_cabs;
    t_det              n_dabs;
    logic [NUMW-1:0]   n_num, n_den;

    // prep: magnitudes, numerator 2*|c|*2^(2F) + |det|, denominator 2*|det|
    always_comb begin
        n_cabs = i_cof[CW-1] ? -i_cof : i_cof;
        n_dabs = i_det[DETW-1] ? -i_det : i_det;
        n_num  = (NUMW'(n_cabs[CW-2:0]) << SHIFT) + NUMW'(n_dabs[DETW-2:0]);
        n_den  = NUMW'({n_dabs[DETW-2:0], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]    <= n_num;
            r_d[0]    <= n_den;
            r_q[0]    <= '0;
            r_neg[0]  <= i_cof[CW-1] ^ i_det[DETW-1];
            r_zero[0] <= (i_det == '0);
            r_big[0]  <= 1'b0;
        end
    end

    // one restoring step per stage, quotient msb first
    for (genvar s = 0; s < DATA_WIDTH; s++) begin : g_step
        localparam int K = DATA_WIDTH - 1 - s;
        logic [CMPW-1:0] w_r, w_dk;
        logic            w_ge, w_big;

        assign w_r  = CMPW'(r_r[s]);
        assign w_dk = CMPW'(r_d[s]) << K;
        assign w_ge = (w_r >= w_dk);

        if (s == 0) begin : g_big
            // quotient at or above 2^DATA_WIDTH: saturate whatever the sign
            assign w_big = (w_r >= (CMPW'(r_d[s]) << DATA_WIDTH));
        end else begin : g_hold
            assign w_big = r_big[s];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[s+1]    <= w_ge ? NUMW'(w_r - w_dk) : r_r[s];
                r_d[s+1]    <= r_d[s];
                r_q[s+1]    <= {r_q[s][DATA_WIDTH-2:0], w_ge};
                r_neg[s+1]  <= r_neg[s];
                r_zero[s+1] <= r_zero[s];
                r_big[s+1]  <= w_big;
            end
        end
    end

    always_comb begin
        logic [DATA_WIDTH-1:0] q;
        logic                  pos_sat, neg_sat;
        q       = r_q[DATA_WIDTH];
        pos_sat = r_big[DATA_WIDTH] | q[DATA_WIDTH-1];
        neg_sat = r_big[DATA_WIDTH] | (q[DATA_WIDTH-1] & (|q[DATA_WIDTH-2:0]));
        n_res.zero = r_zero[DATA_WIDTH];
        if (r_zero[DATA_WIDTH]) begin
            n_res.res = '0;
            n_res.sat = 1'b0;
        end else if (!r_neg[DATA_WIDTH] && pos_sat) begin
            n_res.res = DATA_MAX;
            n_res.sat = 1'b1;
        end else if (r_neg[DATA_WIDTH] && neg_sat) begin
            n_res.res = DATA_MIN;
            n_res.sat = 1'b1;
        end else begin
            n_res.res = r_neg[DATA_WIDTH] ? -$signed(q) : $signed(q);
            n_res.sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

// ----- src/matrix3x3_inverse.sv -----
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out.
// Input channel i_mat: one beat carries the nine elements a00..a22 of one matrix.
// Output channel o_inv: one beat carries the nine inverse elements r00..r22,
//   a singular flag (determinant exactly zero, all elements zero) and an
//   overflow flag (at least one element saturated to the Q16.16 range).
// Nine lanes each form one 2x2 cofactor; a shared stage forms the determinant
//   from lanes 0, 3 and 6; each lane then divides its cofactor by the
//   determinant with a 32-stage restoring divider, rounds half away from zero
//   and saturates. The merge at the output ORs the lane overflow flags.
// Throughput: one matrix per cycle while the receiver takes results; the divider
//   pipeline depth, one quotient bit per stage, sets the latency, not the rate.
// Reset (i_rst_n low at a clock edge) drops every beat in flight and holds
//   i_mat.ready low; data registers have no reset and go on advancing with the enable.
// When the receiver stalls with a result waiting, the whole pipeline holds,
//   bubbles included, and i_mat.ready drops in the same cycle.
module matrix3x3_inverse import mi3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mi3_mat_if.sink    i_mat,
    mi3_inv_if.source  o_inv
);
    logic            w_en, w_acc;
    logic [LAT-1:0]  r_vld;
    t_data           w_a    [LANES];
    t_data           r_a1   [3];
    t_data           r_a2   [3];
    t_cof            w_c    [LANES];
    t_cof            r_c1   [LANES];
    t_cof            r_c2   [LANES];
    t_cof            w_cdet [3];
    t_det            w_det;
    t_lane_res       w_res  [LANES];

    // advance everything unless a finished result is stuck at the output
    assign w_en        = !r_vld[LAT-1] || o_inv.ready;
    assign i_mat.ready = w_en && i_rst_n;
    assign w_acc       = i_mat.valid && i_mat.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    assign w_a[0] = i_mat.a00;
    assign w_a[1] = i_mat.a01;
    assign w_a[2] = i_mat.a02;
    assign w_a[3] = i_mat.a10;
    assign w_a[4] = i_mat.a11;
    assign w_a[5] = i_mat.a12;
    assign w_a[6] = i_mat.a20;
    assign w_a[7] = i_mat.a21;
    assign w_a[8] = i_mat.a22;

    // cofactor lanes
    for (genvar k = 0; k < LANES; k++) begin : g_cof
        mi3_cof u_cof (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_p   (w_a[COF_P[k]]),
            .i_q   (w_a[COF_Q[k]]),
            .i_r   (w_a[COF_R[k]]),
            .i_s   (w_a[COF_S[k]]),
            .o_cof (w_c[k])
        );
    end

    // hold the first row and the cofactors in step with the determinant
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_a1[j] <= w_a[j];
                r_a2[j] <= r_a1[j];
            end
            for (int k = 0; k < LANES; k++) begin
                r_c1[k] <= w_c[k];
                r_c2[k] <= r_c1[k];
            end
        end
    end

    // first-row expansion uses c00, c10, c20
    assign w_cdet[0] = w_c[0];
    assign w_cdet[1] = w_c[3];
    assign w_cdet[2] = w_c[6];

    mi3_det u_det (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_a2),
        .i_c   (w_cdet),
        .o_det (w_det)
    );

    // divider lanes
    for (genvar k = 0; k < LANES; k++) begin : g_div
        mi3_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_cof (r_c2[k]),
            .i_det (w_det),
            .o_res (w_res[k])
        );
    end

    // merge lane results into the result beat
    assign o_inv.valid    = r_vld[LAT-1];
    assign o_inv.r00      = w_res[0].res;
    assign o_inv.r01      = w_res[1].res;
    assign o_inv.r02      = w_res[2].res;
    assign o_inv.r10      = w_res[3].res;
    assign o_inv.r11      = w_res[4].res;
    assign o_inv.r12      = w_res[5].res;
    assign o_inv.r20      = w_res[6].res;
    assign o_inv.r21      = w_res[7].res;
    assign o_inv.r22      = w_res[8].res;
    assign o_inv.singular = w_res[0].zero;
    assign o_inv.overflow = w_res[0].sat | w_res[1].sat | w_res[2].sat | w_res[3].sat
                          | w_res[4].sat | w_res[5].sat | w_res[6].sat | w_res[7].sat
                          | w_res[8].sat;

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && o_inv.singular) |-> (!o_inv.overflow
            && o_inv.r00 == '0 && o_inv.r01 == '0 && o_inv.r02 == '0
            && o_inv.r10 == '0 && o_inv.r11 == '0 && o_inv.r12 == '0
            && o_inv.r20 == '0 && o_inv.r21 == '0 && o_inv.r22 == '0))
        else $error("singular result carries nonzero data");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && !o_inv.ready) |-> !i_mat.ready)
        else $error("input taken while output stalled");

    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && o_inv.overflow) |->
            (o_inv.r00 == DATA_MAX || o_inv.r00 == DATA_MIN
          || o_inv.r01 == DATA_MAX || o_inv.r01 == DATA_MIN
          || o_inv.r02 == DATA_MAX || o_inv.r02 == DATA_MIN
          || o_inv.r10 == DATA_MAX || o_inv.r10 == DATA_MIN
          || o_inv.r11 == DATA_MAX || o_inv.r11 == DATA_MIN
          || o_inv.r12 == DATA_MAX || o_inv.r12 == DATA_MIN
          || o_inv.r20 == DATA_MAX || o_inv.r20 == DATA_MIN
          || o_inv.r21 == DATA_MAX || o_inv.r21 == DATA_MIN
          || o_inv.r22 == DATA_MAX || o_inv.r22 == DATA_MIN))
        else $error("overflow flagged without a saturated element");
endmodule
